// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, types and character classes for the C source
// identifier truncator.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int HEAD_KEEP   = 10;
   localparam int TAIL_DEPTH  = 53;
   localparam int KEEP_RESET  = 36;
   localparam int KEEP_CAP    = 63;
   localparam int KEEP_W      = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam int LEN_W   = 7;
   localparam int LEN_MAX = 127;

   localparam int HEAD_IW = (HEAD_KEEP > 1) ? $clog2(HEAD_KEEP) : 1;
   localparam int HEAD_CW = $clog2(HEAD_KEEP + 1);
   localparam int TAIL_AW = $clog2(TAIL_DEPTH);
   localparam int TAIL_CW = $clog2(TAIL_DEPTH + 1);
   localparam int KEEP_TOP = (HEAD_KEEP + TAIL_DEPTH < KEEP_CAP) ?
                             (HEAD_KEEP + TAIL_DEPTH) : KEEP_CAP;

   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_E_LO   = 8'h65;
   localparam logic [7:0] CH_X_LO   = 8'h78;
   localparam logic [7:0] CH_X_UP   = 8'h58;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_USCORE = 8'h5f;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   typedef enum logic [3:0] {
      LX_NORMAL     = 4'd0,
      LX_STR        = 4'd1,
      LX_STR_ESC    = 4'd2,
      LX_SLASH      = 4'd3,
      LX_COMMENT    = 4'd4,
      LX_CSTAR      = 4'd5,
      LX_IDENT      = 4'd6,
      LX_DEC_INT    = 4'd7,
      LX_DEC_FRAC   = 4'd8,
      LX_EXP_SIGN   = 4'd9,
      LX_EXP_FIRST  = 4'd10,
      LX_EXP_DIGITS = 4'd11,
      LX_ZERO       = 4'd12,
      LX_HEX        = 4'd13,
      LX_OCT        = 4'd14
   } lex_mode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HEAD,
      BK_TAIL_RD,
      BK_TAIL_OUT,
      BK_BYTE
   } back_state_type;

   typedef enum logic [0:0] {
      CMD_BYTE,
      CMD_FLUSH
   } cmd_kind_type;

   // one queued job: a plain byte, or an identifier flush with an optional
   // trailing byte
   typedef struct packed {
      cmd_kind_type         kind;
      logic [7:0]           data;
      logic                 has_byte;
      logic                 trunc;
      logic [HEAD_CW-1:0]   head_cnt;
      logic [TAIL_CW-1:0]   tail_cnt;
      logic [TAIL_AW-1:0]   tail_start;
   } cmd_type;

   typedef struct packed {
      logic                 en;
      logic                 to_head;
      logic [HEAD_IW-1:0]   head_idx;
      logic [TAIL_AW-1:0]   tail_idx;
      logic [7:0]           data;
   } store_wr_type;

   function automatic logic is_dec(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_oct(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h37);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return is_dec(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
             ((b >= 8'h41) && (b <= 8'h46));
   endfunction

   function automatic logic is_ident_start(input logic [7:0] b);
      return is_alpha(b) || (b == CH_USCORE);
   endfunction

   function automatic logic is_ident(input logic [7:0] b);
      return is_ident_start(b) || is_dec(b);
   endfunction

   // mode entered when a byte is taken as plain text
   function automatic lex_mode_type normal_next(input logic [7:0] b);
      lex_mode_type m;
      m = LX_NORMAL;
      if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
         m = LX_STR;
      end else if (b == CH_SLASH) begin
         m = LX_SLASH;
      end else if (is_ident_start(b)) begin
         m = LX_IDENT;
      end else if (is_dec(b)) begin
         m = (b == CH_ZERO) ? LX_ZERO : LX_DEC_INT;
      end
      return m;
   endfunction

endpackage

// ===== hdl/cst_req_if.sv =====
// ----------------------------------------------------------------------------
// cst_req_if
// Request channel: one source byte or an end-of-input marker.
// ----------------------------------------------------------------------------
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_input;

   modport source (output valid, output byte_in, output end_of_input, input ready);
   modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

// ===== hdl/cst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cst_rsp_if
// Response channel: one byte of the filtered stream.
// ----------------------------------------------------------------------------
interface cst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       last;
   logic       was_truncated;

   modport source (output valid, output byte_out, output last, output was_truncated,
                   input ready);
   modport sink   (input valid, input byte_out, input last, input was_truncated,
                   output ready);
endinterface

// ===== hdl/cst_front.sv =====
// ----------------------------------------------------------------------------
// cst_front
// Lexer front end: classifies each request, tracks identifier length and
// store pointers, and queues byte and flush jobs for the back end.
// ----------------------------------------------------------------------------
module cst_front
   import cst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cst_req_if.sink           req_chan,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data,
   input  logic              queue_full,
   input  logic              flush_done,
   output logic              cmd_push,
   output cmd_type           cmd,
   output store_wr_type      store_wr
);

   lex_mode_type         mode_ff, mode_in;
   logic                 quote_ff, quote_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [TAIL_AW-1:0]   wp_ff, wp_in;
   logic [KEEP_W-1:0]    keep_ff;
   logic                 flush_busy_ff, flush_busy_in;

   logic                 accept;
   logic [7:0]           b;
   lex_mode_type         route_mode;
   logic                 route_quote;
   logic                 emit, flush, add, start_id;

   logic [LEN_W-1:0]     keep_lo, eff_keep, total, head_n, tail_raw, tail_n;
   logic [LEN_W-1:0]     start_sum, start_pos;
   logic                 trunc;
   logic [LEN_W-1:0]     base_len;
   logic [TAIL_AW-1:0]   base_wp;

   // flush jobs read the identifier store; no new request until it is read
   assign req_chan.ready = !queue_full && !flush_busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.byte_in;

   assign route_mode  = normal_next(b);
   assign route_quote = ((b == CH_DQUOTE) || (b == CH_SQUOTE)) ? (b == CH_SQUOTE) :
                        quote_ff;

   // next lexer mode
   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      if (accept) begin
         if (req_chan.end_of_input) begin
            mode_in  = LX_NORMAL;
            quote_in = 1'b0;
         end else begin
            unique case (mode_ff)
               LX_STR: begin
                  if (b == (quote_ff ? CH_SQUOTE : CH_DQUOTE)) begin
                     mode_in = LX_NORMAL;
                  end else if (b == CH_BSLASH) begin
                     mode_in = LX_STR_ESC;
                  end
               end
               LX_STR_ESC: begin
                  mode_in = LX_STR;
               end
               LX_SLASH: begin
                  if (b == CH_STAR) begin
                     mode_in = LX_COMMENT;
                  end else begin
                     mode_in  = route_mode;
                     quote_in = route_quote;
                  end
               end
               LX_COMMENT: begin
                  if (b == CH_STAR) begin
                     mode_in = LX_CSTAR;
                  end
               end
               LX_CSTAR: begin
                  if (b == CH_SLASH) begin
                     mode_in = LX_NORMAL;
                  end else if (b == CH_STAR) begin
                     mode_in = LX_CSTAR;
                  end else begin
                     mode_in = LX_COMMENT;
                  end
               end
               LX_IDENT: begin
                  if (!is_ident(b)) begin
                     mode_in  = route_mode;
                     quote_in = route_quote;
                  end
               end
               LX_DEC_INT: begin
                  if (!is_dec(b)) begin
                     mode_in = (b == CH_DOT)  ? LX_DEC_FRAC :
                               (b == CH_E_LO) ? LX_EXP_SIGN : LX_NORMAL;
                  end
               end
               LX_DEC_FRAC: begin
                  if (!is_dec(b)) begin
                     mode_in = (b == CH_E_LO) ? LX_EXP_SIGN : LX_NORMAL;
                  end
               end
               LX_EXP_SIGN: begin
                  mode_in = ((b == CH_PLUS) || (b == CH_MINUS)) ? LX_EXP_FIRST :
                            is_dec(b) ? LX_EXP_DIGITS : LX_NORMAL;
               end
               LX_EXP_FIRST: begin
                  mode_in = is_dec(b) ? LX_EXP_DIGITS : LX_NORMAL;
               end
               LX_EXP_DIGITS: begin
                  if (!is_dec(b)) begin
                     mode_in = LX_NORMAL;
                  end
               end
               LX_ZERO: begin
                  mode_in = ((b == CH_X_LO) || (b == CH_X_UP)) ? LX_HEX :
                            is_oct(b) ? LX_OCT : LX_NORMAL;
               end
               LX_HEX: begin
                  if (!is_hex(b)) begin
                     mode_in = LX_NORMAL;
                  end
               end
               LX_OCT: begin
                  if (!is_oct(b)) begin
                     mode_in = LX_NORMAL;
                  end
               end
               default: begin
                  mode_in  = route_mode;
                  quote_in = route_quote;
               end
            endcase
         end
      end
   end

   // per-request actions
   always_comb begin
      emit     = 1'b0;
      flush    = 1'b0;
      add      = 1'b0;
      start_id = 1'b0;
      if (accept) begin
         if (req_chan.end_of_input) begin
            flush = (mode_ff == LX_IDENT);
         end else begin
            unique case (mode_ff) inside
               LX_STR, LX_STR_ESC, LX_COMMENT, LX_CSTAR, LX_DEC_INT, LX_DEC_FRAC,
               LX_EXP_SIGN, LX_EXP_FIRST, LX_EXP_DIGITS, LX_ZERO, LX_HEX,
               LX_OCT: begin
                  emit = 1'b1;
               end
               LX_SLASH: begin
                  if (b == CH_STAR) begin
                     emit = 1'b1;
                  end else begin
                     emit     = !is_ident_start(b);
                     start_id = is_ident_start(b);
                  end
               end
               LX_IDENT: begin
                  if (is_ident(b)) begin
                     add = 1'b1;
                  end else begin
                     flush = 1'b1;
                     emit  = 1'b1;
                  end
               end
               default: begin
                  emit     = !is_ident_start(b);
                  start_id = is_ident_start(b);
               end
            endcase
         end
      end
   end

   // flush descriptor from the current identifier
   always_comb begin
      keep_lo   = (LEN_W'(keep_ff) < LEN_W'(HEAD_KEEP)) ? LEN_W'(HEAD_KEEP) :
                  LEN_W'(keep_ff);
      eff_keep  = (keep_lo > LEN_W'(KEEP_TOP)) ? LEN_W'(KEEP_TOP) : keep_lo;
      trunc     = (len_ff > eff_keep);
      total     = trunc ? eff_keep : len_ff;
      head_n    = (len_ff < LEN_W'(HEAD_KEEP)) ? len_ff : LEN_W'(HEAD_KEEP);
      tail_raw  = total - head_n;
      tail_n    = (tail_raw > LEN_W'(TAIL_DEPTH)) ? LEN_W'(TAIL_DEPTH) : tail_raw;
      start_sum = LEN_W'(wp_ff) + LEN_W'(TAIL_DEPTH) - tail_n;
      start_pos = (start_sum >= LEN_W'(TAIL_DEPTH)) ? (start_sum - LEN_W'(TAIL_DEPTH)) :
                  start_sum;
   end

   always_comb begin
      cmd_push       = flush || emit;
      cmd.kind       = flush ? CMD_FLUSH : CMD_BYTE;
      cmd.data       = b;
      cmd.has_byte   = emit;
      cmd.trunc      = trunc;
      cmd.head_cnt   = head_n[HEAD_CW-1:0];
      cmd.tail_cnt   = tail_n[TAIL_CW-1:0];
      cmd.tail_start = start_pos[TAIL_AW-1:0];
   end

   // identifier store write and pointer bookkeeping
   always_comb begin
      base_len          = start_id ? '0 : len_ff;
      base_wp           = start_id ? '0 : wp_ff;
      store_wr.en       = add || start_id;
      store_wr.to_head  = (base_len < LEN_W'(HEAD_KEEP));
      store_wr.head_idx = base_len[HEAD_IW-1:0];
      store_wr.tail_idx = base_wp;
      store_wr.data     = b;
      len_in            = len_ff;
      wp_in             = wp_ff;
      if (store_wr.en) begin
         len_in = (base_len == LEN_W'(LEN_MAX)) ? base_len : (base_len + 1'b1);
         if (store_wr.to_head) begin
            wp_in = base_wp;
         end else begin
            wp_in = (base_wp == TAIL_AW'(TAIL_DEPTH - 1)) ? '0 : (base_wp + 1'b1);
         end
      end
      flush_busy_in = (flush_busy_ff && !flush_done) || flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= LX_NORMAL;
         quote_ff      <= 1'b0;
         len_ff        <= '0;
         wp_ff         <= '0;
         keep_ff       <= KEEP_W'(KEEP_RESET);
         flush_busy_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         quote_ff      <= quote_in;
         len_ff        <= len_in;
         wp_ff         <= wp_in;
         flush_busy_ff <= flush_busy_in;
         if (csr_wr_en) begin
            keep_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== hdl/cst_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// cst_cmd_queue
// Short job queue between the lexer front end and the output back end.
// ----------------------------------------------------------------------------
module cst_cmd_queue
   import cst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == QCW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/cst_back.sv =====
// ----------------------------------------------------------------------------
// cst_back
// Output back end: holds the identifier store, runs byte and flush jobs and
// drives the registered response stage.
// ----------------------------------------------------------------------------
module cst_back
   import cst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic         cmd_empty,
   output logic         cmd_pop,
   input  store_wr_type store_wr,
   output logic         flush_done,
   cst_rsp_if.source    rsp_chan
);

   back_state_type      state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   logic [HEAD_CW-1:0]  head_idx_ff, head_idx_in;
   logic [TAIL_CW-1:0]  tail_idx_ff, tail_idx_in;
   logic [TAIL_AW-1:0]  tail_ptr_ff, tail_ptr_in;

   logic [7:0]          head_ff [HEAD_KEEP];
   logic [7:0]          ring_mem [TAIL_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                rd_en;

   logic                out_valid_ff;
   logic [7:0]          out_data_ff;
   logic                out_last_ff;
   logic                out_trunc_ff;

   logic                out_free;
   logic                head_last, tail_last;
   logic                load;
   logic [7:0]          load_data;
   logic                load_last, load_trunc;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign head_last = (HEAD_CW'(head_idx_ff + 1'b1) == cur_ff.head_cnt);
   assign tail_last = (TAIL_CW'(tail_idx_ff + 1'b1) == cur_ff.tail_cnt);

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.byte_out      = out_data_ff;
   assign rsp_chan.last          = out_last_ff;
   assign rsp_chan.was_truncated = out_trunc_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && (cmd.kind == CMD_FLUSH)) begin
               state_in = BK_HEAD;
            end
         end
         BK_HEAD: begin
            if (out_free && head_last) begin
               state_in = (cur_ff.tail_cnt != '0) ? BK_TAIL_RD :
                          cur_ff.has_byte ? BK_BYTE : BK_IDLE;
            end
         end
         BK_TAIL_RD: begin
            state_in = BK_TAIL_OUT;
         end
         BK_TAIL_OUT: begin
            if (out_free) begin
               state_in = !tail_last ? BK_TAIL_RD :
                          cur_ff.has_byte ? BK_BYTE : BK_IDLE;
            end
         end
         BK_BYTE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop     = 1'b0;
      flush_done  = 1'b0;
      rd_en       = 1'b0;
      load        = 1'b0;
      load_data   = cur_ff.data;
      load_last   = 1'b1;
      load_trunc  = 1'b0;
      cur_in      = cur_ff;
      head_idx_in = head_idx_ff;
      tail_idx_in = tail_idx_ff;
      tail_ptr_in = tail_ptr_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               if (cmd.kind == CMD_FLUSH) begin
                  cmd_pop     = 1'b1;
                  cur_in      = cmd;
                  head_idx_in = '0;
                  tail_idx_in = '0;
                  tail_ptr_in = cmd.tail_start;
               end else if (out_free) begin
                  cmd_pop   = 1'b1;
                  load      = 1'b1;
                  load_data = cmd.data;
               end
            end
         end
         BK_HEAD: begin
            if (out_free) begin
               load        = 1'b1;
               load_data   = head_ff[head_idx_ff[HEAD_IW-1:0]];
               load_last   = head_last && (cur_ff.tail_cnt == '0) && !cur_ff.has_byte;
               load_trunc  = cur_ff.trunc;
               head_idx_in = head_idx_ff + 1'b1;
               flush_done  = head_last && (cur_ff.tail_cnt == '0);
            end
         end
         BK_TAIL_RD: begin
            rd_en = 1'b1;
         end
         BK_TAIL_OUT: begin
            if (out_free) begin
               load        = 1'b1;
               load_data   = rd_data_ff;
               load_last   = tail_last && !cur_ff.has_byte;
               load_trunc  = cur_ff.trunc;
               tail_idx_in = tail_idx_ff + 1'b1;
               tail_ptr_in = (tail_ptr_ff == TAIL_AW'(TAIL_DEPTH - 1)) ? '0 :
                             (tail_ptr_ff + 1'b1);
               flush_done  = tail_last;
            end
         end
         BK_BYTE: begin
            if (out_free) begin
               load = 1'b1;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // identifier store
   always_ff @(posedge clock) begin
      if (store_wr.en && store_wr.to_head) begin
         head_ff[store_wr.head_idx] <= store_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr.en && !store_wr.to_head) begin
         ring_mem[store_wr.tail_idx] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[tail_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      head_idx_ff <= head_idx_in;
      tail_idx_ff <= tail_idx_in;
      tail_ptr_ff <= tail_ptr_in;
      if (load) begin
         out_data_ff  <= load_data;
         out_last_ff  <= load_last;
         out_trunc_ff <= load_trunc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== hdl/c_source_identifier_truncator.sv =====
// ----------------------------------------------------------------------------
// c_source_identifier_truncator
// Echoes a C source byte stream, cutting identifiers longer than the keep
// length (csr value, at least ten) to their first ten and last characters.
// ----------------------------------------------------------------------------
//   channel    dir   handshake        payload
//   req_chan   in    valid / ready    byte_in[7:0], end_of_input
//   rsp_chan   out   valid / ready    byte_out[7:0], last, was_truncated
//   csr_*      in    csr_wr_en        csr_wr_data[5:0] (keep_length)
//
// One request per cycle while no identifier flush is outstanding and the job
// queue is not full. A request that ends an identifier holds off further
// requests until the back end has read the kept bytes: head bytes go out one
// per cycle while the response side takes them, each tail byte after a
// registered ring read. Plain bytes pass the job queue and response register;
// the 4-entry job queue lets the lexer run on while the response side stalls.
// Synchronous active-high reset; keep_length resets to 36, no clearing pass.
// ----------------------------------------------------------------------------
module c_source_identifier_truncator
   import cst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cst_req_if.sink           req_chan,
   cst_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [KEEP_W-1:0] csr_wr_data
);

   cmd_type      push_cmd;
   cmd_type      head_cmd;
   logic         cmd_push, cmd_pop;
   logic         queue_full, queue_empty;
   logic         flush_done;
   store_wr_type store_wr;

   cst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .flush_done  (flush_done),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd),
      .store_wr    (store_wr)
   );

   cst_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   cst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (head_cmd),
      .cmd_empty  (queue_empty),
      .cmd_pop    (cmd_pop),
      .store_wr   (store_wr),
      .flush_done (flush_done),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== hdl/cst_checker.sv =====
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on the response stream of the identifier truncator.
// ----------------------------------------------------------------------------
module cst_checker
   import cst_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_last,
   input logic       rsp_was_truncated
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out) &&
                                 $stable(rsp_last) && $stable(rsp_was_truncated))
      else $error("response changed while stalled");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // only an identifier flush yields more than one byte per request
   a_nonlast_ident : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> is_ident(rsp_byte_out))
      else $error("non-final byte is not an identifier character");

   a_trunc_ident : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_truncated |-> is_ident(rsp_byte_out))
      else $error("truncated byte is not an identifier character");

endmodule

bind c_source_identifier_truncator cst_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_byte_out      (rsp_chan.byte_out),
   .rsp_last          (rsp_chan.last),
   .rsp_was_truncated (rsp_chan.was_truncated)
);

// ===== sim/tb_c_source_identifier_truncator.sv =====
// ----------------------------------------------------------------------------
// tb_c_source_identifier_truncator
// Streams C-like source bytes into the truncator and checks every output
// byte against a typed row value or a behavioral lexer kept in step with the
// accepted requests. A short table of hand-picked requests comes first, then
// random token streams under several keep lengths with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_c_source_identifier_truncator
   import cst_pkg::*;
();

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       trunc;
   } out_byte_type;

   // chk: expectation typed in the row (cnt bytes, 0 or 1), else predicted
   typedef struct packed {
      logic [7:0] b;
      logic       eoi;
      logic       chk;
      logic       cnt;
      logic [7:0] want;
   } dir_row_type;

   localparam int DIR_N        = 27;
   localparam int PHASE_N      = 6;
   localparam int PHASE_ITEMS  = 30;
   localparam int DRAIN_CYCLES = 200;

   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{"a",       1'b0, 1'b1, 1'b0, 8'h00},
      '{8'h5a,     1'b1, 1'b1, 1'b1, "a"},        // pending identifier flushed
      '{8'h00,     1'b0, 1'b1, 1'b1, 8'h00},
      '{8'hff,     1'b0, 1'b1, 1'b1, 8'hff},      // high bytes are plain text
      '{CH_SQUOTE, 1'b0, 1'b1, 1'b1, CH_SQUOTE},
      '{CH_DQUOTE, 1'b0, 1'b1, 1'b1, CH_DQUOTE},
      '{CH_BSLASH, 1'b0, 1'b1, 1'b1, CH_BSLASH},
      '{CH_SQUOTE, 1'b0, 1'b1, 1'b1, CH_SQUOTE},  // escaped quote
      '{CH_SQUOTE, 1'b0, 1'b1, 1'b1, CH_SQUOTE},
      '{CH_SLASH,  1'b0, 1'b1, 1'b1, CH_SLASH},
      '{"q",       1'b0, 1'b1, 1'b0, 8'h00},      // slash without star
      '{CH_SLASH,  1'b0, 1'b0, 1'b0, 8'h00},
      '{CH_STAR,   1'b0, 1'b1, 1'b1, CH_STAR},
      '{CH_STAR,   1'b0, 1'b1, 1'b1, CH_STAR},
      '{CH_STAR,   1'b0, 1'b1, 1'b1, CH_STAR},    // star not closing
      '{CH_SLASH,  1'b0, 1'b1, 1'b1, CH_SLASH},
      '{CH_ZERO,   1'b0, 1'b0, 1'b0, 8'h00},
      '{CH_X_UP,   1'b0, 1'b0, 1'b0, 8'h00},
      '{"f",       1'b0, 1'b0, 1'b0, 8'h00},
      '{CH_DOT,    1'b0, 1'b0, 1'b0, 8'h00},
      '{"7",       1'b0, 1'b0, 1'b0, 8'h00},
      '{CH_E_LO,   1'b0, 1'b0, 1'b0, 8'h00},
      '{CH_PLUS,   1'b0, 1'b0, 1'b0, 8'h00},
      '{"5",       1'b0, 1'b0, 1'b0, 8'h00},
      '{" ",       1'b0, 1'b0, 1'b0, 8'h00},
      '{CH_DQUOTE, 1'b0, 1'b1, 1'b1, CH_DQUOTE},
      '{8'h00,     1'b1, 1'b1, 1'b0, 8'h00}       // end inside a string
   };

   localparam logic [7:0] SEPS [10] = '{8'h20, 8'h0a, 8'h09, 8'h3b, 8'h2c,
                                        8'h28, 8'h29, 8'h3d, 8'h7b, 8'h7d};

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [KEEP_W-1:0] csr_wr_data;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();

   c_source_identifier_truncator uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // lexer copy
   lex_mode_type      lx_mode;
   logic              lx_quote;
   logic [7:0]        id_head [HEAD_KEEP];
   logic [7:0]        id_tail [TAIL_DEPTH];
   int                id_wptr;
   int                id_len;
   logic [KEEP_W-1:0] keep_reg;

   out_byte_type expected_bytes [$];
   out_byte_type step_bytes [$];
   out_byte_type rsp_want;
   int           mismatch_count;
   int           sent_count;
   logic         calm;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic digit_ch(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic octal_ch(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h37;
   endfunction

   function automatic logic letter_ch(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
   endfunction

   function automatic logic hexdig_ch(input logic [7:0] b);
      return digit_ch(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
   endfunction

   function automatic void put_byte(input logic [7:0] b, input logic t);
      if (step_bytes.size() < 64) step_bytes.push_back('{b, 1'b0, t});
   endfunction

   function automatic int keep_eff();
      int l;
      l = keep_reg;
      if (l < HEAD_KEEP) l = HEAD_KEEP;
      if (l > HEAD_KEEP + TAIL_DEPTH) l = HEAD_KEEP + TAIL_DEPTH;
      if (l > KEEP_CAP) l = KEEP_CAP;
      return l;
   endfunction

   function automatic void id_push(input logic [7:0] b);
      int p;
      if (id_len < HEAD_KEEP) begin
         id_head[id_len] = b;
      end else begin
         p = id_wptr;
         if (p >= TAIL_DEPTH) p = 0;
         id_tail[p] = b;
         p++;
         if (p >= TAIL_DEPTH) p = 0;
         id_wptr = p;
      end
      if (id_len < LEN_MAX) id_len++;
   endfunction

   function automatic void id_flush();
      int   l, total, head, tail, start, i;
      logic t;
      l = keep_eff();
      t = id_len > l;
      total = t ? l : id_len;
      head = (id_len < HEAD_KEEP) ? id_len : HEAD_KEEP;
      for (i = 0; i < head; i++) put_byte(id_head[i], t);
      tail = (total > head) ? total - head : 0;
      if (tail > TAIL_DEPTH) tail = TAIL_DEPTH;
      start = (id_wptr % TAIL_DEPTH + TAIL_DEPTH - tail) % TAIL_DEPTH;
      for (i = 0; i < tail; i++) put_byte(id_tail[(start + i) % TAIL_DEPTH], t);
   endfunction

   function automatic void lex_byte(input logic [7:0] b);
      logic again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (lx_mode)
            LX_STR: begin
               put_byte(b, 1'b0);
               if (b == (lx_quote ? CH_SQUOTE : CH_DQUOTE)) lx_mode = LX_NORMAL;
               else if (b == CH_BSLASH) lx_mode = LX_STR_ESC;
            end
            LX_STR_ESC: begin
               put_byte(b, 1'b0);
               lx_mode = LX_STR;
            end
            LX_SLASH: begin
               if (b == CH_STAR) begin
                  put_byte(b, 1'b0);
                  lx_mode = LX_COMMENT;
               end else begin
                  lx_mode = LX_NORMAL;
                  again = 1'b1;
               end
            end
            LX_COMMENT: begin
               put_byte(b, 1'b0);
               if (b == CH_STAR) lx_mode = LX_CSTAR;
            end
            LX_CSTAR: begin
               if (b == CH_SLASH) begin
                  put_byte(b, 1'b0);
                  lx_mode = LX_NORMAL;
               end else begin
                  lx_mode = LX_COMMENT;
                  again = 1'b1;
               end
            end
            LX_IDENT: begin
               if (letter_ch(b) || digit_ch(b) || b == CH_USCORE) begin
                  id_push(b);
               end else begin
                  id_flush();
                  lx_mode = LX_NORMAL;
                  again = 1'b1;
               end
            end
            LX_DEC_INT: begin
               put_byte(b, 1'b0);
               if (!digit_ch(b)) begin
                  lx_mode = (b == CH_DOT) ? LX_DEC_FRAC :
                            (b == CH_E_LO) ? LX_EXP_SIGN : LX_NORMAL;
               end
            end
            LX_DEC_FRAC: begin
               put_byte(b, 1'b0);
               if (!digit_ch(b)) lx_mode = (b == CH_E_LO) ? LX_EXP_SIGN : LX_NORMAL;
            end
            LX_EXP_SIGN: begin
               put_byte(b, 1'b0);
               lx_mode = (b == CH_PLUS || b == CH_MINUS) ? LX_EXP_FIRST :
                         digit_ch(b) ? LX_EXP_DIGITS : LX_NORMAL;
            end
            LX_EXP_FIRST: begin
               put_byte(b, 1'b0);
               lx_mode = digit_ch(b) ? LX_EXP_DIGITS : LX_NORMAL;
            end
            LX_EXP_DIGITS: begin
               put_byte(b, 1'b0);
               if (!digit_ch(b)) lx_mode = LX_NORMAL;
            end
            LX_ZERO: begin
               put_byte(b, 1'b0);
               lx_mode = (b == CH_X_LO || b == CH_X_UP) ? LX_HEX :
                         octal_ch(b) ? LX_OCT : LX_NORMAL;
            end
            LX_HEX: begin
               put_byte(b, 1'b0);
               if (!hexdig_ch(b)) lx_mode = LX_NORMAL;
            end
            LX_OCT: begin
               put_byte(b, 1'b0);
               if (!octal_ch(b)) lx_mode = LX_NORMAL;
            end
            default: begin
               lx_mode = LX_NORMAL;
               if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                  put_byte(b, 1'b0);
                  lx_quote = (b == CH_SQUOTE);
                  lx_mode = LX_STR;
               end else if (b == CH_SLASH) begin
                  put_byte(b, 1'b0);
                  lx_mode = LX_SLASH;
               end else if (letter_ch(b) || b == CH_USCORE) begin
                  id_len = 0;
                  id_wptr = 0;
                  id_push(b);
                  lx_mode = LX_IDENT;
               end else if (digit_ch(b)) begin
                  put_byte(b, 1'b0);
                  lx_mode = (b == CH_ZERO) ? LX_ZERO : LX_DEC_INT;
               end else begin
                  put_byte(b, 1'b0);
               end
            end
         endcase
      end
   endfunction

   // output bytes caused by one request, left in step_bytes
   function automatic void filter_request(input logic [7:0] b, input logic eoi);
      out_byte_type tmp;
      step_bytes.delete();
      if (eoi) begin
         if (lx_mode == LX_IDENT) id_flush();
         lx_mode = LX_NORMAL;
         lx_quote = 1'b0;
      end else begin
         lex_byte(b);
      end
      if (step_bytes.size() > 0) begin
         tmp = step_bytes[step_bytes.size() - 1];
         tmp.last = 1'b1;
         step_bytes[step_bytes.size() - 1] = tmp;
      end
   endfunction

   task automatic send_req(input logic [7:0] b, input logic eoi, input logic chk,
                           input logic cnt, input logic [7:0] want);
      while (!calm && $urandom_range(99) < 13) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.byte_in      <= b;
      req_bus.end_of_input <= eoi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      filter_request(b, eoi);
      if (!chk) begin
         foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      end else if (cnt) begin
         expected_bytes.push_back('{want, 1'b1, 1'b0});
      end
      sent_count++;
   endtask

   task automatic send_plain(input logic [7:0] b);
      send_req(b, 1'b0, 1'b0, 1'b0, 8'h00);
   endtask

   function automatic logic [7:0] ident_char(input logic first);
      int r;
      r = first ? $urandom_range(52) : $urandom_range(62);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      if (r == 52) return CH_USCORE;
      return 8'(8'h30 + r - 53);
   endfunction

   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 16);
   endfunction

   task automatic send_digits(input int n);
      for (int i = 0; i < n; i++) send_plain(8'(8'h30 + $urandom_range(9)));
   endtask

   task automatic send_token();
      int         kind, n, r;
      logic [7:0] q;
      kind = $urandom_range(99);
      if (kind < 30) begin
         r = $urandom_range(99);
         n = (r < 80) ? $urandom_range(20, 1) :
             (r < 95) ? $urandom_range(70, 21) : $urandom_range(140, 71);
         send_plain(ident_char(1'b1));
         for (int i = 1; i < n; i++) send_plain(ident_char(1'b0));
         send_plain(SEPS[$urandom_range(9)]);
      end else if (kind < 45) begin
         r = $urandom_range(2);
         if (r == 0) begin
            send_plain(8'(8'h31 + $urandom_range(8)));
            send_digits($urandom_range(5));
            if ($urandom_range(2) == 0) begin
               send_plain(CH_DOT);
               send_digits($urandom_range(4));
            end
            if ($urandom_range(2) == 0) begin
               send_plain(CH_E_LO);
               r = $urandom_range(2);
               if (r == 1) send_plain(CH_PLUS);
               else if (r == 2) send_plain(CH_MINUS);
               send_digits($urandom_range(3, 1));
            end
         end else if (r == 1) begin
            send_plain(CH_ZERO);
            send_plain($urandom_range(1) ? CH_X_LO : CH_X_UP);
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++) send_plain(hex_char());
         end else begin
            send_plain(CH_ZERO);
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) send_plain(8'(8'h30 + $urandom_range(9)));
         end
         send_plain(SEPS[$urandom_range(9)]);
      end else if (kind < 60) begin
         q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
         send_plain(q);
         n = $urandom_range(12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) send_plain(CH_BSLASH);
            send_plain(8'(8'h20 + $urandom_range(94)));
         end
         if ($urandom_range(9) != 0) send_plain(q);
      end else if (kind < 70) begin
         send_plain(CH_SLASH);
         send_plain(CH_STAR);
         n = $urandom_range(12);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(3);
            send_plain(r == 0 ? CH_STAR : r == 1 ? CH_SLASH :
                       8'(8'h20 + $urandom_range(94)));
         end
         if ($urandom_range(9) != 0) begin
            send_plain(CH_STAR);
            send_plain(CH_SLASH);
         end
      end else if (kind < 85) begin
         send_plain(SEPS[$urandom_range(9)]);
      end else if (kind < 95) begin
         send_plain(8'($urandom_range(255)));
      end else begin
         send_req(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 8'h00);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_keep(input logic [KEEP_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      keep_reg = v;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 13);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected output byte %h last %b was_truncated %b",
                        rsp_bus.byte_out, rsp_bus.last, rsp_bus.was_truncated);
            end
         end else begin
            rsp_want = expected_bytes.pop_front();
            if (rsp_bus.byte_out !== rsp_want.data || rsp_bus.last !== rsp_want.last ||
                rsp_bus.was_truncated !== rsp_want.trunc) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: byte_out exp %h got %h, last exp %b got %b, %s %b got %b",
                           rsp_want.data, rsp_bus.byte_out, rsp_want.last, rsp_bus.last,
                           "was_truncated exp", rsp_want.trunc, rsp_bus.was_truncated);
               end
            end
         end
      end
   end

   initial begin
      logic [KEEP_W-1:0] keeps [PHASE_N];
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.byte_in      = 8'h00;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      calm                 = 1'b0;
      mismatch_count       = 0;
      sent_count           = 0;
      lx_mode              = LX_NORMAL;
      lx_quote             = 1'b0;
      id_wptr              = 0;
      id_len               = 0;
      keep_reg             = KEEP_W'(KEEP_RESET);
      keeps = '{6'd0, 6'd63, 6'd10, 6'd9, 6'd62, 6'd0};
      keeps[PHASE_N - 1] = KEEP_W'($urandom_range(63));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_N; i++) begin
         send_req(DIR_ROWS[i].b, DIR_ROWS[i].eoi, DIR_ROWS[i].chk, DIR_ROWS[i].cnt,
                  DIR_ROWS[i].want);
      end
      wait_drained();

      for (int p = 0; p < PHASE_N; p++) begin
         set_keep(keeps[p]);
         calm = (p == 2);
         sent_count = 0;
         while (sent_count < PHASE_ITEMS) send_token();
         // end of file flushes any pending identifier before the next write
         send_req(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 8'h00);
         wait_drained();
      end

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cst_pkg.sv
hdl/cst_req_if.sv
hdl/cst_rsp_if.sv
hdl/cst_front.sv
hdl/cst_cmd_queue.sv
hdl/cst_back.sv
hdl/c_source_identifier_truncator.sv
hdl/cst_checker.sv
sim/tb_c_source_identifier_truncator.sv
